// ----- hw/rtl/bps_pkg.sv -----
// Shared types, codes and step tables of the buzzer pattern sequencer.
package bps_pkg;

  // Item kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_START_PAT = 2'd1,
    OP_START_SOS = 2'd2,
    OP_STOP_SOS  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_BIP_START_HZ  = 3'd1,
    REG_BIP_END_HZ    = 3'd2,
    REG_BOP_HZ        = 3'd3,
    REG_BIP_FIRST_MS  = 3'd4,
    REG_BIP_SECOND_MS = 3'd5,
    REG_BOP_MS        = 3'd6
  } reg_e;

  // Tone source of one step.
  typedef enum logic [1:0] {
    FREQ_OFF       = 2'd0,
    FREQ_BIP_START = 2'd1,
    FREQ_BIP_END   = 2'd2,
    FREQ_BOP       = 2'd3
  } freq_e;

  // Duration source of one step.
  typedef enum logic [1:0] {
    DUR_LIT    = 2'd0,
    DUR_FIRST  = 2'd1,
    DUR_SECOND = 2'd2,
    DUR_BOP    = 2'd3
  } dur_e;

  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned HzW      = 16;
  localparam int unsigned MsW      = 16;
  localparam int unsigned LitMsW   = 11;
  localparam int unsigned PatW     = 3;
  localparam int unsigned StepNumW = 4;
  localparam int unsigned StepIdxW = 5;
  localparam int unsigned ElW      = 8;

  localparam logic [PatW-1:0]     PatNone  = 3'd0;
  localparam logic [PatW-1:0]     PatIdMax = 3'd6;
  localparam logic [StepIdxW-1:0] SosBase  = 5'd26;

  typedef struct packed {
    freq_e             freq;
    dur_e              dur;
    logic [LitMsW-1:0] lit_ms;
  } step_t;

  typedef struct packed {
    logic           enable;
    logic [HzW-1:0] bip_start_hz;
    logic [HzW-1:0] bip_end_hz;
    logic [HzW-1:0] bop_hz;
    logic [MsW-1:0] bip_first_ms;
    logic [MsW-1:0] bip_second_ms;
    logic [MsW-1:0] bop_ms;
  } cfg_t;

  typedef struct packed {
    logic [PatW-1:0]     active_pattern;
    logic [StepNumW-1:0] step_number;
    logic                step_running;
    logic [MsW-1:0]      step_elapsed;
    logic                sos_on;
    logic [1:0]          sos_step;
    logic                sos_running;
    logic [MsW-1:0]      sos_elapsed;
    logic [HzW-1:0]      tone_now;
  } state_t;

  typedef struct packed {
    logic            request_taken;
    logic            sos_playing;
    logic [PatW-1:0] playing_pattern;
    logic [HzW-1:0]  tone_hz;
  } res_t;

  // Flat step list: distance bip, confirm, fault, pairing, tracker, shutdown, SOS.
  function automatic step_t step_lookup(input logic [StepIdxW-1:0] idx);
    step_t s;
    unique case (idx)
      5'd0:  s = '{FREQ_BIP_START, DUR_FIRST,  11'd0};
      5'd1:  s = '{FREQ_BIP_END,   DUR_SECOND, 11'd0};
      5'd2:  s = '{FREQ_BOP,       DUR_BOP,    11'd0};
      5'd3:  s = '{FREQ_BOP,       DUR_LIT,    11'd180};
      5'd4:  s = '{FREQ_OFF,       DUR_LIT,    11'd120};
      5'd5:  s = '{FREQ_BOP,       DUR_LIT,    11'd180};
      5'd6:  s = '{FREQ_OFF,       DUR_LIT,    11'd120};
      5'd7:  s = '{FREQ_BOP,       DUR_LIT,    11'd180};
      5'd8:  s = '{FREQ_BOP,       DUR_BOP,    11'd0};
      5'd9:  s = '{FREQ_OFF,       DUR_LIT,    11'd400};
      5'd10: s = '{FREQ_BOP,       DUR_BOP,    11'd0};
      5'd11: s = '{FREQ_BOP,       DUR_BOP,    11'd0};
      5'd12: s = '{FREQ_OFF,       DUR_LIT,    11'd250};
      5'd13: s = '{FREQ_BIP_START, DUR_FIRST,  11'd0};
      5'd14: s = '{FREQ_BIP_END,   DUR_SECOND, 11'd0};
      5'd15: s = '{FREQ_OFF,       DUR_LIT,    11'd250};
      5'd16: s = '{FREQ_BOP,       DUR_BOP,    11'd0};
      5'd17: s = '{FREQ_OFF,       DUR_LIT,    11'd250};
      5'd18: s = '{FREQ_BIP_START, DUR_FIRST,  11'd0};
      5'd19: s = '{FREQ_BIP_END,   DUR_SECOND, 11'd0};
      5'd20: s = '{FREQ_OFF,       DUR_LIT,    11'd250};
      5'd21: s = '{FREQ_BOP,       DUR_BOP,    11'd0};
      5'd22: s = '{FREQ_OFF,       DUR_LIT,    11'd250};
      5'd23: s = '{FREQ_BIP_START, DUR_FIRST,  11'd0};
      5'd24: s = '{FREQ_BIP_END,   DUR_SECOND, 11'd0};
      5'd25: s = '{FREQ_BOP,       DUR_LIT,    11'd80};
      5'd26: s = '{FREQ_BIP_START, DUR_LIT,    11'd120};
      5'd27: s = '{FREQ_OFF,       DUR_LIT,    11'd120};
      5'd28: s = '{FREQ_BIP_START, DUR_LIT,    11'd120};
      5'd29: s = '{FREQ_OFF,       DUR_LIT,    11'd1640};
      default: s = '{FREQ_OFF,     DUR_LIT,    11'd0};
    endcase
    return s;
  endfunction

  function automatic logic [StepIdxW-1:0] pat_base(input logic [PatW-1:0] pid);
    logic [StepIdxW-1:0] b;
    unique case (pid)
      3'd2:    b = 5'd2;
      3'd3:    b = 5'd3;
      3'd4:    b = 5'd8;
      3'd5:    b = 5'd11;
      3'd6:    b = 5'd25;
      default: b = 5'd0;
    endcase
    return b;
  endfunction

  function automatic logic [StepNumW-1:0] pat_count(input logic [PatW-1:0] pid);
    logic [StepNumW-1:0] c;
    unique case (pid)
      3'd1:    c = 4'd2;
      3'd2:    c = 4'd1;
      3'd3:    c = 4'd5;
      3'd4:    c = 4'd3;
      3'd5:    c = 4'd14;
      3'd6:    c = 4'd1;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pat_prio(input logic [PatW-1:0] pid);
    logic [2:0] p;
    unique case (pid)
      3'd1:    p = 3'd4;
      3'd2:    p = 3'd2;
      3'd3:    p = 3'd5;
      3'd4:    p = 3'd6;
      3'd5:    p = 3'd7;
      3'd6:    p = 3'd3;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/bps_cfg_regs.sv -----
// Configuration register file of the buzzer pattern sequencer.
module bps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [bps_pkg::RegIdxW-1:0]   wr_addr_i,
  input  logic [bps_pkg::MsW-1:0]       wr_data_i,
  output bps_pkg::cfg_t                 cfg_o
);

  bps_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (bps_pkg::reg_e'(wr_addr_i))
        bps_pkg::REG_ENABLE:        cfg_d.enable        = wr_data_i[0];
        bps_pkg::REG_BIP_START_HZ:  cfg_d.bip_start_hz  = wr_data_i;
        bps_pkg::REG_BIP_END_HZ:    cfg_d.bip_end_hz    = wr_data_i;
        bps_pkg::REG_BOP_HZ:        cfg_d.bop_hz        = wr_data_i;
        bps_pkg::REG_BIP_FIRST_MS:  cfg_d.bip_first_ms  = wr_data_i;
        bps_pkg::REG_BIP_SECOND_MS: cfg_d.bip_second_ms = wr_data_i;
        bps_pkg::REG_BOP_MS:        cfg_d.bop_ms        = wr_data_i;
        default:                    cfg_d = cfg_q;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b1;
      cfg_q.bip_start_hz  <= 16'd2000;
      cfg_q.bip_end_hz    <= 16'd3000;
      cfg_q.bop_hz        <= 16'd800;
      cfg_q.bip_first_ms  <= 16'd60;
      cfg_q.bip_second_ms <= 16'd60;
      cfg_q.bop_ms        <= 16'd150;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/bps_core.sv -----
// Sequencer state and its one-beat update for ticks, pattern and SOS requests.
module bps_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  bps_pkg::op_e                  op_i,
  input  logic [bps_pkg::PatW-1:0]      pattern_id_i,
  input  logic [bps_pkg::ElW-1:0]       elapsed_ms_i,
  input  bps_pkg::cfg_t                 cfg_i,
  output bps_pkg::state_t               state_o,
  output bps_pkg::res_t                 res_o
);

  bps_pkg::state_t st_q, st_d;
  logic            taken;

  logic [bps_pkg::StepIdxW-1:0] sos_idx, pat_idx, cur_idx;
  logic [bps_pkg::StepIdxW:0]   pat_idx_sum;
  bps_pkg::step_t               cur_step;
  logic [bps_pkg::HzW-1:0]      cur_freq;
  logic [bps_pkg::MsW-1:0]      cur_dur;
  logic [bps_pkg::MsW-1:0]      run_el;
  logic [bps_pkg::MsW:0]        el_sum;
  logic [bps_pkg::MsW-1:0]      el_sat;
  logic                         step_done;
  logic [bps_pkg::StepNumW-1:0] pat_cnt;
  logic [bps_pkg::StepNumW-1:0] step_nxt;
  logic                         pid_ok, prio_ok;

  // One step lookup serves whichever sequence is running.
  assign sos_idx     = bps_pkg::SosBase + {3'b000, st_q.sos_step};
  assign pat_idx_sum = {1'b0, bps_pkg::pat_base(st_q.active_pattern)}
                     + {2'b00, st_q.step_number};
  assign pat_idx     = pat_idx_sum[bps_pkg::StepIdxW-1:0];
  assign cur_idx     = st_q.sos_on ? sos_idx : pat_idx;
  assign cur_step    = bps_pkg::step_lookup(cur_idx);

  always_comb begin
    unique case (cur_step.freq)
      bps_pkg::FREQ_BIP_START: cur_freq = cfg_i.bip_start_hz;
      bps_pkg::FREQ_BIP_END:   cur_freq = cfg_i.bip_end_hz;
      bps_pkg::FREQ_BOP:       cur_freq = cfg_i.bop_hz;
      default:                 cur_freq = '0;
    endcase
    unique case (cur_step.dur)
      bps_pkg::DUR_FIRST:  cur_dur = cfg_i.bip_first_ms;
      bps_pkg::DUR_SECOND: cur_dur = cfg_i.bip_second_ms;
      bps_pkg::DUR_BOP:    cur_dur = cfg_i.bop_ms;
      default:             cur_dur = {5'b0, cur_step.lit_ms};
    endcase
  end

  // Shared saturating step timer add and end-of-step compare.
  assign run_el    = st_q.sos_on ? st_q.sos_elapsed : st_q.step_elapsed;
  assign el_sum    = {1'b0, run_el} + {9'b0, elapsed_ms_i};
  assign el_sat    = el_sum[bps_pkg::MsW] ? '1 : el_sum[bps_pkg::MsW-1:0];
  assign step_done = (el_sat >= cur_dur);

  assign pat_cnt  = bps_pkg::pat_count(st_q.active_pattern);
  assign step_nxt = st_q.step_number + 4'd1;

  assign pid_ok  = (pattern_id_i != bps_pkg::PatNone) && (pattern_id_i <= bps_pkg::PatIdMax);
  assign prio_ok = (st_q.active_pattern == bps_pkg::PatNone) ||
                   (bps_pkg::pat_prio(pattern_id_i) >= bps_pkg::pat_prio(st_q.active_pattern));

  always_comb begin
    st_d  = st_q;
    taken = 1'b0;
    if (cfg_i.enable) begin
      unique case (op_i)
        bps_pkg::OP_TICK: begin
          if (st_q.sos_on) begin
            if (!st_q.sos_running) begin
              st_d.tone_now    = cur_freq;
              st_d.sos_elapsed = '0;
              st_d.sos_running = 1'b1;
            end else begin
              st_d.sos_elapsed = el_sat;
              if (step_done) begin
                st_d.tone_now    = '0;
                st_d.sos_step    = st_q.sos_step + 2'd1;
                st_d.sos_running = 1'b0;
              end
            end
          end else if (st_q.active_pattern != bps_pkg::PatNone) begin
            if (st_q.step_number >= pat_cnt) begin
              // index ran off the end of the pattern
              st_d.tone_now       = '0;
              st_d.active_pattern = bps_pkg::PatNone;
              st_d.step_running   = 1'b0;
            end else if (!st_q.step_running) begin
              st_d.tone_now     = cur_freq;
              st_d.step_elapsed = '0;
              st_d.step_running = 1'b1;
            end else begin
              st_d.step_elapsed = el_sat;
              if (step_done) begin
                st_d.tone_now     = '0;
                st_d.step_number  = step_nxt;
                st_d.step_running = 1'b0;
                if (step_nxt >= pat_cnt) begin
                  st_d.active_pattern = bps_pkg::PatNone;
                end
              end
            end
          end
        end
        bps_pkg::OP_START_PAT: begin
          if (!st_q.sos_on && pid_ok && prio_ok) begin
            st_d.active_pattern = pattern_id_i;
            st_d.step_number    = '0;
            st_d.step_running   = 1'b0;
            taken               = 1'b1;
          end
        end
        bps_pkg::OP_START_SOS: begin
          taken = 1'b1;
          if (!st_q.sos_on) begin
            st_d.sos_on         = 1'b1;
            st_d.active_pattern = bps_pkg::PatNone;
            st_d.step_running   = 1'b0;
            st_d.sos_step       = '0;
            st_d.sos_running    = 1'b0;
          end
        end
        bps_pkg::OP_STOP_SOS: begin
          if (st_q.sos_on) begin
            st_d.sos_on      = 1'b0;
            st_d.sos_step    = '0;
            st_d.sos_running = 1'b0;
            st_d.tone_now    = '0;
          end
        end
        default: st_d = st_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

  assign res_o.request_taken   = taken;
  assign res_o.sos_playing     = st_d.sos_on;
  assign res_o.playing_pattern = st_d.active_pattern;
  assign res_o.tone_hz         = st_d.tone_now;
  assign state_o               = st_q;

endmodule

// ----- hw/rtl/buzzer_pattern_sequencer_unit.sv -----
// Top level of the buzzer pattern sequencer: stream ports, beat registers, checks.
//
// Buzzer tone sequencer. Every input beat is a tick (elapsed milliseconds), a
// request to start one of six fixed tone patterns, start SOS or stop SOS, and
// every input beat yields exactly one output beat with the tone now driven,
// the pattern now playing, the SOS flag and whether a start request was taken.
// Throughput is one beat per clock while the output side is not held back. A
// beat passes the input register, then the state update and result register.
// The rate is set by the state update itself: one step table lookup, one
// 16-bit saturating add and one compare, all combinational. The input register
// keeps accepting while a finished result waits in the output register, so
// back pressure only stalls the input once both are full.
// Configuration writes are always accepted (cfg_ready_o is tied high) and take
// effect on the next cycle; write them only while no beat is in flight.
// Pattern priorities, highest first: tracker, pairing, fault, distance bip,
// shutdown, confirm. SOS preempts and locks out all patterns until stopped.
module buzzer_pattern_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [2:0] pattern_id, [10:3] elapsed_ms, rest zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] operation
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] tone_hz, [18:16] playing_pattern,
                                        // [19] sos_playing, [20] request_taken, rest zero
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  bps_pkg::cfg_t   cfg;
  bps_pkg::state_t state;
  bps_pkg::res_t   res;

  // input beat register
  logic                         in_valid_q, in_valid_d;
  bps_pkg::op_e                 in_op_q;
  logic [bps_pkg::PatW-1:0]     in_pid_q;
  logic [bps_pkg::ElW-1:0]      in_el_q;

  // output beat register
  logic                         out_valid_q, out_valid_d;
  bps_pkg::res_t                out_res_q;

  logic s_accept;
  logic advance;

  assign cfg_ready_o = 1'b1;

  bps_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i & cfg_ready_o),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // The held beat moves on when the output register is empty or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q  <= bps_pkg::op_e'(s_axis_tuser_i);
      in_pid_q <= s_axis_tdata_i[2:0];
      in_el_q  <= s_axis_tdata_i[10:3];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  bps_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .op_i         (in_op_q),
    .pattern_id_i (in_pid_q),
    .elapsed_ms_i (in_el_q),
    .cfg_i        (cfg),
    .state_o      (state),
    .res_o        (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_res_q};

  // SOS and a pattern never play at the same time.
  a_sos_excludes_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.sos_on |-> (state.active_pattern == bps_pkg::PatNone))
    else $error("SOS active together with a pattern");

  // A running pattern step always belongs to an active pattern.
  a_step_needs_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.step_running |-> (state.active_pattern != bps_pkg::PatNone))
    else $error("pattern step running with no pattern");

  // A running SOS step only exists while SOS is on.
  a_sos_step_needs_sos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.sos_running |-> state.sos_on)
    else $error("SOS step running with SOS off");

  // Every beat that leaves the input register lands in the output register.
  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after state update");

endmodule

// ----- tb/sv/tb_buzzer_pattern_sequencer_unit.sv -----
// Self-checking testbench: predicts every output beat of the sequencer and compares it.
module tb_buzzer_pattern_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Pattern ids as they travel in tdata; 0 and 7 are not patterns.
  localparam logic [2:0] PatBad      = 3'd7;
  localparam logic [2:0] PatDistance = 3'd1;
  localparam logic [2:0] PatConfirm  = 3'd2;
  localparam logic [2:0] PatFault    = 3'd3;
  localparam logic [2:0] PatPairing  = 3'd4;
  localparam logic [2:0] PatTracker  = 3'd5;
  localparam logic [2:0] PatShutdown = 3'd6;

  // First entry of the SOS loop in the flat step list.
  localparam logic [4:0] SosFirstStep = 5'd26;

  // Pipeline is the input register then the output register; the settle wait lets everything drain.
  localparam int unsigned SettleCycles = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [2:0] pattern_id, [10:3] elapsed_ms, rest zero
  logic [1:0]  s_axis_tuser_i;   // [1:0] operation
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;   // [15:0] tone_hz, [18:16] playing_pattern,
                                 // [19] sos_playing, [20] request_taken, rest zero
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i;
  logic [15:0] cfg_data_i;

  buzzer_pattern_sequencer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Idle percentages of the two stream sides, changed per test.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_cnt;

  // Expected status beats, oldest first.
  bps_pkg::res_t status_q[$];

  // ---------------------------------------------------------------------------
  // Sequencer prediction: registers and state mirrored at the block's widths.
  // ---------------------------------------------------------------------------
  bps_pkg::cfg_t cur_cfg;
  logic [2:0]    cur_pat;
  logic [3:0]    cur_step;
  logic          step_live;
  logic [15:0]   step_ms;
  logic          sos_loop;
  logic [1:0]    sos_idx;
  logic          sos_live;
  logic [15:0]   sos_ms;
  logic [15:0]   tone_drive;

  // Per pattern id: first step, number of steps, priority.
  logic [4:0] pat_first_tab [8] = '{5'd0, 5'd0, 5'd2, 5'd3, 5'd8, 5'd11, 5'd25, 5'd0};
  logic [3:0] pat_len_tab   [8] = '{4'd0, 4'd2, 4'd1, 4'd5, 4'd3, 4'd14, 4'd1, 4'd0};
  logic [2:0] pat_rank_tab  [8] = '{3'd0, 3'd4, 3'd2, 3'd5, 3'd6, 3'd7, 3'd3, 3'd0};

  // Tone of one step of the flat list, from the current registers.
  function automatic logic [15:0] step_tone(logic [4:0] idx);
    case (idx)
      5'd0, 5'd13, 5'd18, 5'd23, 5'd26, 5'd28:
        return cur_cfg.bip_start_hz;
      5'd1, 5'd14, 5'd19, 5'd24:
        return cur_cfg.bip_end_hz;
      5'd2, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd11, 5'd16, 5'd21, 5'd25:
        return cur_cfg.bop_hz;
      default:
        return 16'd0;
    endcase
  endfunction

  // Length of one step in ms: register driven or fixed.
  function automatic logic [15:0] step_len(logic [4:0] idx);
    case (idx)
      5'd0, 5'd13, 5'd18, 5'd23:                  return cur_cfg.bip_first_ms;
      5'd1, 5'd14, 5'd19, 5'd24:                  return cur_cfg.bip_second_ms;
      5'd2, 5'd8, 5'd10, 5'd11, 5'd16, 5'd21:     return cur_cfg.bop_ms;
      5'd3, 5'd5, 5'd7:                           return 16'd180;
      5'd4, 5'd6, 5'd26, 5'd27, 5'd28:            return 16'd120;
      5'd9:                                       return 16'd400;
      5'd12, 5'd15, 5'd17, 5'd20, 5'd22:          return 16'd250;
      5'd25:                                      return 16'd80;
      5'd29:                                      return 16'd1640;
      default:                                    return 16'd0;
    endcase
  endfunction

  // Applies one accepted beat to the mirrored state and returns the status beat.
  function automatic bps_pkg::res_t next_status(bps_pkg::op_e op, logic [2:0] pid,
                                                logic [7:0] el);
    bps_pkg::res_t r;
    logic          taken;
    logic [4:0]    idx;
    logic [3:0]    cnt;
    logic [16:0]   sum;
    taken = 1'b0;
    if (cur_cfg.enable) begin
      case (op)
        bps_pkg::OP_TICK: begin
          if (sos_loop) begin
            idx = SosFirstStep + {3'd0, sos_idx};
            if (!sos_live) begin
              tone_drive = step_tone(idx);
              sos_ms     = 16'd0;
              sos_live   = 1'b1;
            end else begin
              // timer saturates rather than wrapping
              sum    = {1'b0, sos_ms} + {9'd0, el};
              sos_ms = sum[16] ? 16'hFFFF : sum[15:0];
              if (sos_ms >= step_len(idx)) begin
                tone_drive = 16'd0;
                sos_idx    = sos_idx + 2'd1;
                sos_live   = 1'b0;
              end
            end
          end else if (cur_pat != bps_pkg::PatNone) begin
            cnt = pat_len_tab[cur_pat];
            if (cur_step >= cnt) begin
              tone_drive = 16'd0;
              cur_pat    = bps_pkg::PatNone;
              step_live  = 1'b0;
            end else begin
              idx = pat_first_tab[cur_pat] + {1'b0, cur_step};
              if (!step_live) begin
                tone_drive = step_tone(idx);
                step_ms    = 16'd0;
                step_live  = 1'b1;
              end else begin
                sum     = {1'b0, step_ms} + {9'd0, el};
                step_ms = sum[16] ? 16'hFFFF : sum[15:0];
                if (step_ms >= step_len(idx)) begin
                  tone_drive = 16'd0;
                  cur_step   = cur_step + 4'd1;
                  step_live  = 1'b0;
                  if (cur_step >= cnt) begin
                    cur_pat = bps_pkg::PatNone;
                  end
                end
              end
            end
          end
        end
        bps_pkg::OP_START_PAT: begin
          if (!sos_loop && pid != bps_pkg::PatNone && pid != PatBad &&
              (cur_pat == bps_pkg::PatNone ||
               pat_rank_tab[pid] >= pat_rank_tab[cur_pat])) begin
            cur_pat   = pid;
            cur_step  = 4'd0;
            step_live = 1'b0;
            taken     = 1'b1;
          end
        end
        bps_pkg::OP_START_SOS: begin
          taken = 1'b1;
          if (!sos_loop) begin
            // tone is left as is until the next tick opens the first SOS step
            sos_loop  = 1'b1;
            cur_pat   = bps_pkg::PatNone;
            step_live = 1'b0;
            sos_idx   = 2'd0;
            sos_live  = 1'b0;
          end
        end
        default: begin
          if (sos_loop) begin
            sos_loop   = 1'b0;
            sos_idx    = 2'd0;
            sos_live   = 1'b0;
            tone_drive = 16'd0;
          end
        end
      endcase
    end
    r.tone_hz         = tone_drive;
    r.playing_pattern = cur_pat;
    r.sos_playing     = sos_loop;
    r.request_taken   = taken;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver back pressure, output checker, run limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void log_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk_i) begin
    bps_pkg::res_t exp_beat;
    bps_pkg::res_t got_beat;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_beat = m_axis_tdata_o[20:0];
      if (status_q.size() == 0) begin
        log_fail($sformatf("status beat %06h with none expected", m_axis_tdata_o));
      end else begin
        exp_beat = status_q.pop_front();
        if (got_beat.tone_hz !== exp_beat.tone_hz ||
            got_beat.playing_pattern !== exp_beat.playing_pattern ||
            got_beat.sos_playing !== exp_beat.sos_playing ||
            got_beat.request_taken !== exp_beat.request_taken ||
            m_axis_tdata_o[23:21] !== 3'd0) begin
          log_fail($sformatf({"status mismatch: exp tone %0d pat %0d sos %0b taken %0b,",
                              " got tone %0d pat %0d sos %0b taken %0b pad %0b"},
                             exp_beat.tone_hz, exp_beat.playing_pattern,
                             exp_beat.sos_playing, exp_beat.request_taken,
                             got_beat.tone_hz, got_beat.playing_pattern,
                             got_beat.sos_playing, got_beat.request_taken,
                             m_axis_tdata_o[23:21]));
        end
      end
    end
  end

  // Far beyond the slowest legal run (a few thousand beats with stalls).
  initial begin
    #2_000_000;
    $display("tb_buzzer_pattern_sequencer_unit NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Beat and register drivers.
  // ---------------------------------------------------------------------------

  // Sends one input beat; tvalid stays high afterwards for back-to-back beats.
  task automatic send_item(bps_pkg::op_e op, logic [2:0] pid, logic [7:0] el);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {5'd0, el, pid};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    status_q.push_back(next_status(op, pid, el));
  endtask

  // Drops tvalid and waits until every expected beat is back and the pipe is empty.
  task automatic wait_results_done();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(bps_pkg::reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bps_pkg::REG_ENABLE:        cur_cfg.enable        = val[0];
      bps_pkg::REG_BIP_START_HZ:  cur_cfg.bip_start_hz  = val;
      bps_pkg::REG_BIP_END_HZ:    cur_cfg.bip_end_hz    = val;
      bps_pkg::REG_BOP_HZ:        cur_cfg.bop_hz        = val;
      bps_pkg::REG_BIP_FIRST_MS:  cur_cfg.bip_first_ms  = val;
      bps_pkg::REG_BIP_SECOND_MS: cur_cfg.bip_second_ms = val;
      bps_pkg::REG_BOP_MS:        cur_cfg.bop_ms        = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Writes the whole register set once the block is idle.
  task automatic apply_settings(bps_pkg::cfg_t s);
    wait_results_done();
    write_reg(bps_pkg::REG_ENABLE, {15'd0, s.enable});
    write_reg(bps_pkg::REG_BIP_START_HZ, s.bip_start_hz);
    write_reg(bps_pkg::REG_BIP_END_HZ, s.bip_end_hz);
    write_reg(bps_pkg::REG_BOP_HZ, s.bop_hz);
    write_reg(bps_pkg::REG_BIP_FIRST_MS, s.bip_first_ms);
    write_reg(bps_pkg::REG_BIP_SECOND_MS, s.bip_second_ms);
    write_reg(bps_pkg::REG_BOP_MS, s.bop_ms);
  endtask

  // Elapsed time with extra weight on the two extremes.
  function automatic logic [7:0] elapsed_pick();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Priority, invalid ids, restart on equal priority, first steps of tracker.
  task automatic test_request_rules();
    send_item(bps_pkg::OP_START_PAT, PatTracker, 8'hAA);       // idle: taken
    send_item(bps_pkg::OP_START_PAT, PatConfirm, 8'd0);        // lower priority: refused
    send_item(bps_pkg::OP_START_PAT, bps_pkg::PatNone, 8'd0);  // invalid id
    send_item(bps_pkg::OP_START_PAT, PatBad, 8'd0);            // invalid id
    send_item(bps_pkg::OP_START_PAT, PatPairing, 8'd0);        // still below tracker
    send_item(bps_pkg::OP_START_PAT, PatFault, 8'd0);          // below tracker too
    send_item(bps_pkg::OP_TICK, PatBad, 8'd0);                 // step opens, bop tone
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'hFF);      // past the bop length: silent
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd17);      // pause step opens
    send_item(bps_pkg::OP_START_PAT, PatTracker, 8'd0);        // equal priority restarts
    send_item(bps_pkg::OP_START_PAT, PatShutdown, 8'd0);       // refused
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd0);
  endtask

  // SOS preemption, lockout, repeat start, full loop steps and stop.
  task automatic test_sos_rules();
    send_item(bps_pkg::OP_START_SOS, bps_pkg::PatNone, 8'd0);  // pattern dropped, tone kept
    send_item(bps_pkg::OP_START_PAT, PatTracker, 8'd0);        // locked out
    send_item(bps_pkg::OP_START_SOS, bps_pkg::PatNone, 8'd0);  // taken, no change
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd0);       // first SOS tone
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd120);     // exactly its length
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd0);
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd200);
    send_item(bps_pkg::OP_STOP_SOS, bps_pkg::PatNone, 8'd0);   // silenced
    send_item(bps_pkg::OP_STOP_SOS, bps_pkg::PatNone, 8'd0);   // already off
    send_item(bps_pkg::OP_START_PAT, PatConfirm, 8'd0);
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd0);
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'hFF);      // single step done: pattern clears
  endtask

  // With enable low every beat leaves the state alone.
  task automatic test_disabled();
    send_item(bps_pkg::OP_START_PAT, PatDistance, 8'd0);
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd0);
    wait_results_done();
    write_reg(bps_pkg::REG_ENABLE, 16'd0);
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'hFF);
    send_item(bps_pkg::OP_START_PAT, PatTracker, 8'd0);
    send_item(bps_pkg::OP_START_SOS, bps_pkg::PatNone, 8'd0);
    send_item(bps_pkg::OP_STOP_SOS, bps_pkg::PatNone, 8'd0);
    wait_results_done();
    write_reg(bps_pkg::REG_ENABLE, 16'd1);
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'hFF);
  endtask

  // Longest bop: the step timer must stick at 65535 instead of wrapping.
  task automatic test_timer_saturation();
    bps_pkg::cfg_t s;
    int unsigned   n;
    s        = cur_cfg;
    s.bop_ms = 16'hFFFF;
    apply_settings(s);
    send_item(bps_pkg::OP_START_PAT, PatTracker, 8'd0);
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd0);
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd100);
    n = 0;
    while (cur_step == 4'd0 && n < 300) begin
      send_item(bps_pkg::OP_TICK, 3'($urandom_range(0, 7)), 8'hFF);
      n++;
    end
    send_item(bps_pkg::OP_TICK, bps_pkg::PatNone, 8'd0);
  endtask

  // Mostly well formed bursts (pattern then ticks, SOS loop then stop), some noise.
  task automatic test_random_traffic(bps_pkg::cfg_t s, int unsigned sidle,
                                     int unsigned ridle, int unsigned count);
    int unsigned done;
    int unsigned k;
    int unsigned r;
    apply_settings(s);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_item(bps_pkg::OP_START_PAT, 3'($urandom_range(1, 6)),
                  8'($urandom_range(0, 255)));
        k = $urandom_range(1, 30);
        repeat (k) begin
          if ($urandom_range(0, 99) < 90) begin
            send_item(bps_pkg::OP_TICK, 3'($urandom_range(0, 7)), elapsed_pick());
          end else begin
            send_item(bps_pkg::OP_START_PAT, 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)));
          end
        end
        done += k + 1;
      end else if (r < 80) begin
        send_item(bps_pkg::OP_START_SOS, 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)));
        k = $urandom_range(1, 40);
        repeat (k) begin
          r = $urandom_range(0, 99);
          if (r < 88) begin
            send_item(bps_pkg::OP_TICK, 3'($urandom_range(0, 7)), elapsed_pick());
          end else if (r < 96) begin
            send_item(bps_pkg::OP_START_PAT, 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)));
          end else begin
            send_item(bps_pkg::OP_START_SOS, 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)));
          end
        end
        done += k + 1;
        // now and then SOS is left running into the next burst
        if ($urandom_range(0, 99) < 80) begin
          send_item(bps_pkg::OP_STOP_SOS, 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)));
          done++;
        end
      end else begin
        k = $urandom_range(1, 5);
        repeat (k) begin
          send_item(bps_pkg::op_e'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)));
        end
        done += k;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests.
  // ---------------------------------------------------------------------------
  initial begin
    bps_pkg::cfg_t s;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 16'd0;
    s_axis_tuser_i  = bps_pkg::OP_TICK;
    cfg_valid_i     = 1'b0;
    cfg_addr_i      = bps_pkg::REG_ENABLE;
    cfg_data_i      = 16'd0;
    send_idle_pct   = 29;
    recv_idle_pct   = 47;
    fail_cnt        = 0;

    // reset values of registers and state
    cur_cfg    = '{enable: 1'b1, bip_start_hz: 16'd2000, bip_end_hz: 16'd3000,
                   bop_hz: 16'd800, bip_first_ms: 16'd60, bip_second_ms: 16'd60,
                   bop_ms: 16'd150};
    cur_pat    = bps_pkg::PatNone;
    cur_step   = 4'd0;
    step_live  = 1'b0;
    step_ms    = 16'd0;
    sos_loop   = 1'b0;
    sos_idx    = 2'd0;
    sos_live   = 1'b0;
    sos_ms     = 16'd0;
    tone_drive = 16'd0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_request_rules();
    test_sos_rules();
    test_disabled();
    test_timer_saturation();

    // short random durations, random tones
    s.enable        = 1'b1;
    s.bip_start_hz  = 16'($urandom_range(0, 65535));
    s.bip_end_hz    = 16'($urandom_range(0, 65535));
    s.bop_hz        = 16'($urandom_range(0, 65535));
    s.bip_first_ms  = 16'($urandom_range(0, 300));
    s.bip_second_ms = 16'($urandom_range(0, 300));
    s.bop_ms        = 16'($urandom_range(0, 300));
    test_random_traffic(s, 29, 47, 120);

    // all tones at the top, all register durations zero
    s = '{enable: 1'b1, bip_start_hz: 16'hFFFF, bip_end_hz: 16'hFFFF, bop_hz: 16'hFFFF,
          bip_first_ms: 16'd0, bip_second_ms: 16'd0, bop_ms: 16'd0};
    test_random_traffic(s, 47, 29, 120);

    // silent and top tones mixed, longest and shortest durations
    s = '{enable: 1'b1, bip_start_hz: 16'd0, bip_end_hz: 16'hFFFF, bop_hz: 16'd1,
          bip_first_ms: 16'hFFFF, bip_second_ms: 16'd1, bop_ms: 16'd2};
    test_random_traffic(s, 0, 0, 120);

    // back to the reset values
    s = '{enable: 1'b1, bip_start_hz: 16'd2000, bip_end_hz: 16'd3000, bop_hz: 16'd800,
          bip_first_ms: 16'd60, bip_second_ms: 16'd60, bop_ms: 16'd150};
    test_random_traffic(s, 0, 0, 120);

    // blocks until every expected beat came back; the run limit covers a hang
    wait_results_done();
    if (fail_cnt == 0) begin
      $display("tb_buzzer_pattern_sequencer_unit OK");
    end else begin
      $display("tb_buzzer_pattern_sequencer_unit NOT OK");
    end
    $finish;
  end

endmodule
